@@ hw/rtl/adaa_pkg.sv @@
// Shared types and constants of the antialiased soft clipper.
package adaa_pkg;

  // Sequencer states of the clipper.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_GSET,
    ST_GMUL,
    ST_GFIN,
    ST_CGM,
    ST_CGA,
    ST_YSET,
    ST_DIVY,
    ST_DONE
  } state_t;

  // Products formed by the shared multiplier, in issue order.
  typedef enum logic [3:0] {
    MS_A2,
    MS_A3,
    MS_A4,
    MS_A5,
    MS_B2,
    MS_B3,
    MS_B4,
    MS_B5,
    MS_A4B,
    MS_A3B2,
    MS_A2B3,
    MS_AB4
  } mul_step_t;

  // Unit magnitude of the Q3.12 input.
  localparam logic signed [15:0] UNIT_Q12 = 16'sd4096;
  // Curve bound 0.8 in Q1.14.
  localparam logic [14:0] OUT_LIMIT = 15'd13107;
  // Half of one Q28 unit of the product, used for rounding.
  localparam logic signed [59:0] HALF_Q28 = 60'sd134217728;
  // Half of one output step when a Q28 value is brought to Q1.14.
  localparam logic [29:0] HALF_Q14 = 30'd8192;
  // Half of the divisor thirty, added to the core term for rounding.
  localparam logic [33:0] DIV30_HALF = 34'd15;
  // Two to the 23 divided by fifteen, rounded up; exact for operands below two to the 20.
  localparam logic signed [29:0] RECIP15 = 30'sd559241;
  // Iteration count of the output divider, less one.
  localparam logic [4:0] Y_LAST_BIT = 5'd15;

endpackage

@@ hw/rtl/adaa_soft_clipper.sv @@
// Top level of the first-order antiderivative-antialiased soft clipper.
// A request is taken only in the idle state, so each item holds the block through its
// products on the one shared multiplier and, when the sample differs from the previous
// one, the one-bit-per-cycle restoring divider of the output. The result waits while the
// output register holds a stalled result; a new request is taken the cycle after it is loaded.
// Reset (rst, synchronous) clears the sequencer, the output valid and the stored sample.
module adaa_soft_clipper (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] sample_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample_out
);

  // Clamp a Q3.12 sample to the span of plus or minus one.
  function automatic logic signed [13:0] clamp_unit(input logic signed [15:0] v);
    logic signed [13:0] r;
    if (v > adaa_pkg::UNIT_Q12) begin
      r = 14'(adaa_pkg::UNIT_Q12);
    end else if (v < -adaa_pkg::UNIT_Q12) begin
      r = 14'(-adaa_pkg::UNIT_Q12);
    end else begin
      r = v[13:0];
    end
    return r;
  endfunction

  adaa_pkg::state_t    state, state_next;
  adaa_pkg::mul_step_t step;
  logic                phase;

  // The stored sample that the next request is compared against.
  logic signed [15:0] prev;

  // Per-request terms captured at acceptance.
  logic signed [29:0] a, b;        // clamped samples in Q28
  logic signed [16:0] lin;         // difference of the magnitudes of the parts beyond the clamp
  logic signed [17:0] c5;          // five times the difference of the clamped samples
  logic [18:0]        dmag;        // magnitude of five times the sample difference
  logic               dneg;        // sign of the sample difference
  logic               eq;          // sample equals the stored one

  // Powers built up by the multiplier and the running sum of the fifth-degree terms.
  logic signed [29:0] a2, a3, a4, b2, b3, b4;
  logic signed [32:0] s;
  logic signed [29:0] g;
  logic signed [59:0] prod;
  logic signed [47:0] num;
  logic               tneg, yneg;

  // Division of the core term by thirty: the high part's share of the quotient and the
  // small sum that is left for the reciprocal multiply.
  logic [17:0] wsum;
  logic [29:0] hq;

  // Restoring divider registers.
  logic [47:0] rem, dsh;
  logic [15:0] quo;
  logic [4:0]  cnt;

  logic accept, load_out;

  // Values derived from the incoming sample and the stored one.
  logic signed [13:0] cx, cp;
  logic signed [16:0] ex, ep, mx, mp;
  logic signed [14:0] c_in;
  logic signed [16:0] d_in;
  logic signed [19:0] d5;

  always_comb begin
    cx   = clamp_unit(sample_in);
    cp   = clamp_unit(prev);
    ex   = 17'(sample_in) - 17'(cx);
    ep   = 17'(prev) - 17'(cp);
    mx   = ex[16] ? -ex : ex;
    mp   = ep[16] ? -ep : ep;
    c_in = 15'(cx) - 15'(cp);
    d_in = 17'(sample_in) - 17'(prev);
    d5   = (20'(d_in) <<< 2) + 20'(d_in);
  end

  // Operand selection for the shared multiplier.
  logic signed [29:0] mul_a, mul_b;

  always_comb begin
    mul_a = a;
    mul_b = a;
    if (state == adaa_pkg::ST_CGM) begin
      mul_a = 30'(c5);
      mul_b = g;
    end else if (state == adaa_pkg::ST_GMUL) begin
      mul_a = $signed({12'b0, wsum});
      mul_b = adaa_pkg::RECIP15;
    end else begin
      unique case (step)
        adaa_pkg::MS_A2:   begin mul_a = a;  mul_b = a;  end
        adaa_pkg::MS_A3:   begin mul_a = a2; mul_b = a;  end
        adaa_pkg::MS_A4:   begin mul_a = a3; mul_b = a;  end
        adaa_pkg::MS_A5:   begin mul_a = a4; mul_b = a;  end
        adaa_pkg::MS_B2:   begin mul_a = b;  mul_b = b;  end
        adaa_pkg::MS_B3:   begin mul_a = b2; mul_b = b;  end
        adaa_pkg::MS_B4:   begin mul_a = b3; mul_b = b;  end
        adaa_pkg::MS_B5:   begin mul_a = b4; mul_b = b;  end
        adaa_pkg::MS_A4B:  begin mul_a = a4; mul_b = b;  end
        adaa_pkg::MS_A3B2: begin mul_a = a3; mul_b = b2; end
        adaa_pkg::MS_A2B3: begin mul_a = a2; mul_b = b3; end
        adaa_pkg::MS_AB4:  begin mul_a = a;  mul_b = b4; end
        default:           begin mul_a = a;  mul_b = a;  end
      endcase
    end
  end

  // A registered product is brought back to Q28, rounded to nearest with ties away
  // from zero: a negative value takes one less before the arithmetic shift.
  logic signed [59:0] rnd_sum;
  logic signed [29:0] rnd;

  always_comb begin
    rnd_sum = prod + adaa_pkg::HALF_Q28 - 60'(prod[59]);
    rnd     = 30'(rnd_sum >>> 28);
  end

  // Numerator of the core term: fifteen times the sum less the fifth-degree sum.
  // Its rounded magnitude is halved, then split at bit 17; since two to the 17 is
  // 8738 fifteens plus two, the quotient by fifteen is 8738 times the high part plus
  // the quotient of twice the high part and the low part, which stays below 2^18.
  logic signed [30:0] ab;
  logic signed [35:0] t;
  logic [33:0]        tmag;
  logic [46:0]        nmag;
  logic [32:0]        nt;
  logic [15:0]        nh;
  logic [16:0]        nl;

  always_comb begin
    ab   = 31'(a) + 31'(b);
    t    = (36'(ab) <<< 4) - 36'(ab) - 36'(s);
    tmag = t[35] ? 34'(-t) : 34'(t);
    nmag = num[47] ? 47'(-num) : 47'(num);
    nt   = 33'((tmag + adaa_pkg::DIV30_HALF) >> 1);
    nh   = nt[32:17];
    nl   = nt[16:0];
  end

  // One divider step: subtract the shifted divisor when it fits.
  logic [48:0] diff;
  assign diff = {1'b0, rem} - {1'b0, dsh};

  // Final rounding and saturation of the result.
  logic [29:0]        gmag;
  logic [16:0]        qmag;
  logic               ovf;
  logic [14:0]        ymag;
  logic signed [15:0] y;
  logic signed [29:0] qg;

  always_comb begin
    gmag = g[29] ? 30'(-g) : 30'(g);
    // The reciprocal product carries the quotient in its bits above 23.
    qg   = $signed(hq + 30'(prod[37:23]));
    if (eq) begin
      qmag = 17'((gmag + adaa_pkg::HALF_Q14) >> 14);
      ovf  = 1'b0;
    end else begin
      qmag = {2'b00, quo[14:0]};
      ovf  = quo[15];
    end
    if (ovf || (qmag > 17'(adaa_pkg::OUT_LIMIT))) begin
      ymag = adaa_pkg::OUT_LIMIT;
    end else begin
      ymag = qmag[14:0];
    end
    y = (eq ? g[29] : yneg) ? -$signed({1'b0, ymag}) : $signed({1'b0, ymag});
  end

  // Sequencer: next state and handshake outputs.
  always_comb begin
    state_next = state;
    in_stall   = (state != adaa_pkg::ST_IDLE);
    accept     = in_valid && !in_stall;
    load_out   = 1'b0;
    unique case (state)
      adaa_pkg::ST_IDLE: begin
        if (in_valid) state_next = adaa_pkg::ST_MUL;
      end
      adaa_pkg::ST_MUL: begin
        if (phase && (step == adaa_pkg::MS_AB4)) state_next = adaa_pkg::ST_GSET;
      end
      adaa_pkg::ST_GSET: begin
        state_next = adaa_pkg::ST_GMUL;
      end
      adaa_pkg::ST_GMUL: begin
        state_next = adaa_pkg::ST_GFIN;
      end
      adaa_pkg::ST_GFIN: begin
        state_next = eq ? adaa_pkg::ST_DONE : adaa_pkg::ST_CGM;
      end
      adaa_pkg::ST_CGM: begin
        state_next = adaa_pkg::ST_CGA;
      end
      adaa_pkg::ST_CGA: begin
        state_next = adaa_pkg::ST_YSET;
      end
      adaa_pkg::ST_YSET: begin
        state_next = adaa_pkg::ST_DIVY;
      end
      adaa_pkg::ST_DIVY: begin
        if (cnt == 5'd0) state_next = adaa_pkg::ST_DONE;
      end
      adaa_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = adaa_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= adaa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The stored sample is replaced by each accepted one; the current request keeps its
  // own copies of the terms it needs.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
    end else if (accept) begin
      prev <= sample_in;
    end
  end

  // Datapath: capture, multiplier sequence, divider and result formation.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      step  <= adaa_pkg::MS_A2;
    end else begin
      if (accept) begin
        a     <= {cx, 16'b0};
        b     <= {cp, 16'b0};
        lin   <= mx - mp;
        c5    <= (18'(c_in) <<< 2) + 18'(c_in);
        dmag  <= d5[19] ? 19'(-d5) : 19'(d5);
        dneg  <= d5[19];
        eq    <= (sample_in == prev);
        s     <= '0;
        phase <= 1'b0;
        step  <= adaa_pkg::MS_A2;
      end
      case (state)
        adaa_pkg::ST_MUL: begin
          if (!phase) begin
            prod  <= mul_a * mul_b;
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            step  <= adaa_pkg::mul_step_t'(step + 4'd1);
            case (step)
              adaa_pkg::MS_A2: a2 <= rnd;
              adaa_pkg::MS_A3: a3 <= rnd;
              adaa_pkg::MS_A4: a4 <= rnd;
              adaa_pkg::MS_B2: b2 <= rnd;
              adaa_pkg::MS_B3: b3 <= rnd;
              adaa_pkg::MS_B4: b4 <= rnd;
              default:         s  <= s + 33'(rnd);
            endcase
          end
        end
        adaa_pkg::ST_GSET: begin
          // 8738 times the high part is formed from its shifts.
          wsum <= 18'({nh, 1'b0}) + 18'(nl);
          hq   <= (30'(nh) << 13) + (30'(nh) << 9) + (30'(nh) << 5) + (30'(nh) << 1);
          tneg <= t[35];
        end
        adaa_pkg::ST_GMUL: begin
          prod <= mul_a * mul_b;
        end
        adaa_pkg::ST_DIVY: begin
          if (!diff[48]) begin
            rem <= diff[47:0];
          end
          quo <= {quo[14:0], !diff[48]};
          dsh <= dsh >> 1;
          cnt <= cnt - 5'd1;
        end
        adaa_pkg::ST_GFIN: begin
          g <= tneg ? -qg : qg;
        end
        adaa_pkg::ST_CGM: begin
          prod <= mul_a * mul_b;
        end
        adaa_pkg::ST_CGA: begin
          num <= (48'(lin) <<< 30) + $signed(prod[47:0]);
        end
        adaa_pkg::ST_YSET: begin
          // Sixteen quotient bits are formed; a set top bit means the result saturates.
          rem  <= 48'(nmag) + 48'({dmag, 13'b0});
          dsh  <= {dmag, 29'b0};
          quo  <= '0;
          cnt  <= adaa_pkg::Y_LAST_BIT;
          yneg <= num[47] ^ dneg;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: a finished result waits here while the next request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sample_out <= y;
    end
  end

endmodule
